FILE: sv/bcdau_pkg.sv
package bcdau_pkg;

  localparam int DIGITS_DEF = 16;
  localparam int BCD_W = 64;
  // widest binary value of a 16-digit operand with face-value nibbles
  localparam int VAL_W = 54;
  localparam int ACC_W = VAL_W + 1;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DIFF = 2'd1,
    FUNC_MUL  = 2'd2,
    FUNC_DIV  = 2'd3
  } bcdau_func_e;

  typedef struct packed {
    bcdau_func_e      func;
    logic [BCD_W-1:0] operand_a;
    logic [BCD_W-1:0] operand_b;
  } bcdau_req_t;

  typedef struct packed {
    logic [BCD_W-1:0] result;
    logic             a_at_least_b;
    logic             divide_by_zero;
  } bcdau_rsp_t;

  typedef struct packed {
    bcdau_func_e      func;
    logic [BCD_W-1:0] a_bcd;
    logic [BCD_W-1:0] b_bcd;
    logic [VAL_W-1:0] a_val;
    logic [VAL_W-1:0] b_val;
  } bcdau_conv_t;

  typedef struct packed {
    bcdau_func_e      func;
    logic             ge;
    logic             dz;
    logic [VAL_W-1:0] am;
    logic [VAL_W-1:0] bm;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] diff;
  } bcdau_prep_t;

  typedef struct packed {
    bcdau_func_e      func;
    logic             ge;
    logic             dz;
    logic [ACC_W-1:0] acc;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] q;
    logic [ACC_W-1:0] res;
  } bcdau_arith_t;

  typedef struct packed {
    logic             ge;
    logic             dz;
    logic [VAL_W-1:0] bits;
    logic [BCD_W-1:0] bcd;
  } bcdau_dd_t;

  function automatic logic [VAL_W-1:0] pow10(input int n);
    logic [VAL_W-1:0] p;
    p = VAL_W'(1);
    for (int i = 0; i < n; i++) begin
      p = VAL_W'(p * VAL_W'(10));
    end
    return p;
  endfunction

endpackage

FILE: sv/bcdau_conv_cell.sv
module bcdau_conv_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  bcdau_pkg::bcdau_conv_t data_i,
  output logic                  valid_o,
  output bcdau_pkg::bcdau_conv_t data_o
);

  logic                   valid_q;
  bcdau_pkg::bcdau_conv_t data_q, data_d;

  always_comb begin
    data_d = data_i;
    data_d.a_val = (data_i.a_val << 3) + (data_i.a_val << 1)
                 + bcdau_pkg::VAL_W'(data_i.a_bcd[4*IDX +: 4]);
    data_d.b_val = (data_i.b_val << 3) + (data_i.b_val << 1)
                 + bcdau_pkg::VAL_W'(data_i.b_bcd[4*IDX +: 4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/bcdau_arith_cell.sv
module bcdau_arith_cell #(
  parameter logic [bcdau_pkg::VAL_W-1:0] MODULUS = bcdau_pkg::pow10(bcdau_pkg::DIGITS_DEF)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  bcdau_pkg::bcdau_arith_t data_i,
  output logic                   valid_o,
  output bcdau_pkg::bcdau_arith_t data_o
);

  localparam logic [bcdau_pkg::ACC_W-1:0] MOD_W = {1'b0, MODULUS};

  logic                            valid_q;
  bcdau_pkg::bcdau_arith_t         data_q, data_d;
  logic [bcdau_pkg::ACC_W-1:0]     dbl, sum, rem;
  logic                            rem_ge;

  always_comb begin
    data_d = data_i;
    // multiply: acc = (2 acc + bit * x) mod m
    dbl = {data_i.acc[bcdau_pkg::ACC_W-2:0], 1'b0};
    if (dbl >= MOD_W) begin
      dbl = dbl - MOD_W;
    end
    sum = data_i.y[bcdau_pkg::VAL_W-1] ? dbl + {1'b0, data_i.x} : dbl;
    if (sum >= MOD_W) begin
      sum = sum - MOD_W;
    end
    // divide: restoring step
    rem    = {data_i.acc[bcdau_pkg::ACC_W-2:0], data_i.y[bcdau_pkg::VAL_W-1]};
    rem_ge = rem >= {1'b0, data_i.x};
    if (data_i.func == bcdau_pkg::FUNC_MUL) begin
      data_d.acc = sum;
    end else if (data_i.func == bcdau_pkg::FUNC_DIV) begin
      data_d.acc = rem_ge ? rem - {1'b0, data_i.x} : rem;
      data_d.q   = {data_i.q[bcdau_pkg::VAL_W-2:0], rem_ge};
    end
    data_d.y = {data_i.y[bcdau_pkg::VAL_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/bcdau_dd_cell.sv
module bcdau_dd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  bcdau_pkg::bcdau_dd_t data_i,
  output logic                valid_o,
  output bcdau_pkg::bcdau_dd_t data_o
);

  localparam int NIB = bcdau_pkg::BCD_W / 4;

  logic                         valid_q;
  bcdau_pkg::bcdau_dd_t         data_q, data_d;
  logic [bcdau_pkg::BCD_W-1:0]  adj;

  always_comb begin
    data_d = data_i;
    adj    = data_i.bcd;
    for (int i = 0; i < NIB; i++) begin
      if (data_i.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = data_i.bcd[4*i +: 4] + 4'd3;
      end
    end
    data_d.bcd  = {adj[bcdau_pkg::BCD_W-2:0], data_i.bits[bcdau_pkg::VAL_W-1]};
    data_d.bits = {data_i.bits[bcdau_pkg::VAL_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/bcd_arithmetic_unit.sv
// throughput: one request per cycle while the skid is empty (in_stall_o low);
// fully pipelined digit, bit and bcd cell rows
// a two-entry output register and skid stage decouple the result side
// reset: rst_ni asynchronous active low, clears all valid flags; no clearing pass
module bcd_arithmetic_unit #(
  parameter int DIGITS = bcdau_pkg::DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bcdau_pkg::bcdau_req_t in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bcdau_pkg::bcdau_rsp_t out_rsp_o
);

  localparam int VW = bcdau_pkg::VAL_W;
  localparam int AW = bcdau_pkg::ACC_W;
  localparam logic [VW-1:0] MODULUS = bcdau_pkg::pow10(DIGITS);
  localparam logic [AW-1:0] MOD_W = {1'b0, MODULUS};

  logic en;
  logic skid_valid_q, out_valid_q;
  bcdau_pkg::bcdau_rsp_t skid_q, out_q, last_rsp;

  assign en = !skid_valid_q;

  // bcd to binary
  logic                   cv [DIGITS+1];
  bcdau_pkg::bcdau_conv_t cd [DIGITS+1];

  always_comb begin
    cv[0]          = in_valid_i;
    cd[0].func     = in_req_i.func;
    cd[0].a_bcd    = in_req_i.operand_a;
    cd[0].b_bcd    = in_req_i.operand_b;
    cd[0].a_val    = '0;
    cd[0].b_val    = '0;
  end

  for (genvar k = 0; k < DIGITS; k++) begin : g_conv
    bcdau_conv_cell #(.IDX(DIGITS - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .data_i  (cd[k]),
      .valid_o (cv[k+1]),
      .data_o  (cd[k+1])
    );
  end

  // compare, reduce, difference
  logic                   p1_valid_q;
  bcdau_pkg::bcdau_prep_t p1_q, p1_d;
  logic [VW:0]            a_minus_b;
  bcdau_pkg::bcdau_conv_t cl;

  always_comb begin
    cl          = cd[DIGITS];
    a_minus_b   = {1'b0, cl.a_val} - {1'b0, cl.b_val};
    p1_d.func   = cl.func;
    p1_d.ge     = !a_minus_b[VW];
    p1_d.dz     = (cl.func == bcdau_pkg::FUNC_DIV) && (cl.b_val == '0);
    p1_d.am     = (cl.a_val >= MODULUS) ? cl.a_val - MODULUS : cl.a_val;
    p1_d.bm     = (cl.b_val >= MODULUS) ? cl.b_val - MODULUS : cl.b_val;
    p1_d.a      = cl.a_val;
    p1_d.b      = cl.b_val;
    p1_d.diff   = a_minus_b[VW] ? cl.b_val - cl.a_val : a_minus_b[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= cv[DIGITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && cv[DIGITS]) begin
      p1_q <= p1_d;
    end
  end

  // operand setup for the bit cells
  logic                    av [VW+1];
  bcdau_pkg::bcdau_arith_t ad [VW+1];
  logic                    p2_valid_q;
  bcdau_pkg::bcdau_arith_t p2_q, p2_d;

  always_comb begin
    p2_d.func = p1_q.func;
    p2_d.ge   = p1_q.ge;
    p2_d.dz   = p1_q.dz;
    p2_d.acc  = '0;
    p2_d.q    = '0;
    p2_d.x    = (p1_q.func == bcdau_pkg::FUNC_MUL) ? p1_q.am : p1_q.b;
    p2_d.y    = (p1_q.func == bcdau_pkg::FUNC_MUL) ? p1_q.bm : p1_q.a;
    p2_d.res  = (p1_q.func == bcdau_pkg::FUNC_ADD) ? {1'b0, p1_q.am} + {1'b0, p1_q.bm}
                                                   : {1'b0, p1_q.diff};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && p1_valid_q) begin
      p2_q <= p2_d;
    end
  end

  assign av[0] = p2_valid_q;
  assign ad[0] = p2_q;

  for (genvar k = 0; k < VW; k++) begin : g_arith
    bcdau_arith_cell #(.MODULUS(MODULUS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (av[k]),
      .data_i  (ad[k]),
      .valid_o (av[k+1]),
      .data_o  (ad[k+1])
    );
  end

  // final select and reduction
  logic                 fv_q;
  bcdau_pkg::bcdau_dd_t fd_q, fd_d;
  logic [AW-1:0]        rsel;
  bcdau_pkg::bcdau_arith_t al;

  always_comb begin
    al = ad[VW];
    priority if (al.func == bcdau_pkg::FUNC_MUL) begin
      rsel = al.acc;
    end else if (al.func == bcdau_pkg::FUNC_DIV) begin
      rsel = al.dz ? '0 : {1'b0, al.q};
    end else begin
      rsel = al.res;
    end
    if (rsel >= MOD_W) begin
      rsel = rsel - MOD_W;
    end
    fd_d.ge   = al.ge;
    fd_d.dz   = al.dz;
    fd_d.bits = rsel[VW-1:0];
    fd_d.bcd  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en) begin
      fv_q <= av[VW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && av[VW]) begin
      fd_q <= fd_d;
    end
  end

  // binary to bcd
  logic                 dv [VW+1];
  bcdau_pkg::bcdau_dd_t dd [VW+1];

  assign dv[0] = fv_q;
  assign dd[0] = fd_q;

  for (genvar k = 0; k < VW; k++) begin : g_dd
    bcdau_dd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .data_i  (dd[k]),
      .valid_o (dv[k+1]),
      .data_o  (dd[k+1])
    );
  end

  assign last_rsp.result         = dd[VW].bcd;
  assign last_rsp.a_at_least_b   = dd[VW].ge;
  assign last_rsp.divide_by_zero = dd[VW].dz;

  // output register and skid
  logic take;
  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (dv[VW]) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (dv[VW]) begin
      if (!out_valid_q || take) begin
        out_q <= last_rsp;
      end else begin
        skid_q <= last_rsp;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a response while output register is empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.divide_by_zero |-> out_q.result == '0)
    else $error("divide by zero with nonzero result");

endmodule
